### hdl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg: shared definitions for the block run bump allocator
// Field widths, reset values, status codes and register addresses.
// ----------------------------------------------------------------------------
package bra_pkg;

   // default sizing of the store and its start bitmap
   localparam int MAX_BLOCKS_DEF     = 2048;
   localparam int MARK_WORD_BITS_DEF = 32;

   // payload field widths
   localparam int KIND_W   = 1;
   localparam int SIZE_W   = 27;
   localparam int STORE_W  = 32;
   localparam int OFS_W    = 27;
   localparam int STATUS_W = 2;
   localparam int RSB_W    = 11;

   // block size register and its legal range
   localparam int BS_W = 17;
   localparam logic [BS_W-1:0] BS_MIN   = 17'd16;
   localparam logic [BS_W-1:0] BS_MAX   = 17'd65536;
   localparam logic [BS_W-1:0] BS_RESET = 17'd4096;

   // next free byte offset after reset
   localparam logic [BS_W-1:0] NEXT_FREE_RESET = 17'd8;

   // divider iteration count, one quotient bit per cycle
   localparam int DIV_STEPS = 27;
   localparam int DIV_CNT_W = 5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG_STORE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd3;

   // register addresses
   localparam int PADDR_W = 3;
   localparam logic [PADDR_W-1:0] ADDR_BLOCK_SIZE = 3'h0;
   localparam logic [PADDR_W-1:0] ADDR_STORE_ID   = 3'h4;

endpackage

### hdl/bra_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_req_if: request channel
// Valid/ready handshake carrying one allocate or lookup request.
// ----------------------------------------------------------------------------
interface bra_req_if;
   logic                           valid;
   logic                           ready;
   logic [bra_pkg::KIND_W-1:0]     kind;
   logic [bra_pkg::SIZE_W-1:0]     size;
   logic [bra_pkg::STORE_W-1:0]    query_store;
   logic [bra_pkg::OFS_W-1:0]      offset;

   modport source (output valid, kind, size, query_store, offset, input ready);
   modport sink (input valid, kind, size, query_store, offset, output ready);
endinterface

### hdl/bra_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_rsp_if: result channel
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bra_pkg::STATUS_W-1:0]   status;
   logic [bra_pkg::OFS_W-1:0]      alloc_offset;
   logic [bra_pkg::RSB_W-1:0]      run_start_block;
   logic [bra_pkg::OFS_W-1:0]      offset_in_run;

   modport source (output valid, status, alloc_offset, run_start_block, offset_in_run,
                   input ready);
   modport sink (input valid, status, alloc_offset, run_start_block, offset_in_run,
                 output ready);
endinterface

### hdl/bra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ram: generic single port ram
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

### hdl/block_run_bump_allocator_core.sv
`timescale 1ns / 1ps
// An allocate that fits the top block passes check, multiply and finish; one that opens a
// run adds a 27-step division and the mark update; a lookup adds the division and a scan
// of the bitmap word by word; a wrong store ends at the check, full or out of range
// after the division. One request is in work at a time; allocates and lookups share the
// restoring divider. After reset a clearing pass writes every bitmap word before the first
// request is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// block_run_bump_allocator_core: bump allocator over a store of fixed-size blocks
// Allocates byte offsets and finds the start block of the run holding an offset.
// ----------------------------------------------------------------------------
module block_run_bump_allocator_core #(
   parameter int MAX_BLOCKS     = bra_pkg::MAX_BLOCKS_DEF,
   parameter int MARK_WORD_BITS = bra_pkg::MARK_WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bra_req_if.sink                       req,
   bra_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bra_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   localparam int BLK_W = $clog2(MAX_BLOCKS);
   localparam int WORDS = (MAX_BLOCKS + MARK_WORD_BITS - 1) / MARK_WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W = $clog2(MARK_WORD_BITS);
   localparam int SZ_W  = bra_pkg::SIZE_W;
   localparam int BS_W  = bra_pkg::BS_W;
   localparam int PROD_W = BLK_W + BS_W;

   // sequencer states
   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_CHECK     = 4'd2;
   localparam logic [3:0] S_DIV       = 4'd3;
   localparam logic [3:0] S_DIV_DONE  = 4'd4;
   localparam logic [3:0] S_SPLIT     = 4'd5;
   localparam logic [3:0] S_MARK_WAIT = 4'd6;
   localparam logic [3:0] S_MARK_WR   = 4'd7;
   localparam logic [3:0] S_SCAN_WAIT = 4'd8;
   localparam logic [3:0] S_SCAN      = 4'd9;
   localparam logic [3:0] S_MUL       = 4'd10;
   localparam logic [3:0] S_FIN       = 4'd11;

   logic [3:0] state_ff, state_in;

   // configuration registers
   logic [BS_W-1:0]             bs_reg_ff;
   logic [bra_pkg::STORE_W-1:0] store_id_ff;
   logic [BS_W-1:0]             bs;

   // allocator state
   logic [BLK_W-1:0] top_ff;
   logic [BS_W-1:0]  next_free_ff;

   // latched request
   logic [bra_pkg::KIND_W-1:0]  kind_ff;
   logic [SZ_W-1:0]             size_ff;
   logic [bra_pkg::STORE_W-1:0] qstore_ff;
   logic [bra_pkg::OFS_W-1:0]   offset_ff;

   // working registers
   logic                          fit_ff;
   logic [bra_pkg::STATUS_W-1:0]  status_ff;
   logic [SZ_W-1:0]               dvd_ff;
   logic [BS_W-1:0]               rem_ff;
   logic [BS_W-1:0]               dsr_ff;
   logic [bra_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [BLK_W-1:0]              newtop_ff;
   logic [BS_W-1:0]               bytes_ff;
   logic [BLK_W-1:0]              blk_ff;
   logic [WA_W-1:0]               word_ff;
   logic [BIT_W-1:0]              pos_ff;
   logic [BLK_W-1:0]              mul_a_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [WA_W-1:0]               clr_ff;

   // result registers
   logic                          rsp_valid_ff;
   logic [bra_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [bra_pkg::OFS_W-1:0]     rsp_aoff_ff;
   logic [bra_pkg::RSB_W-1:0]     rsp_rsb_ff;
   logic [bra_pkg::OFS_W-1:0]     rsp_inrun_ff;

   // bitmap memory port
   logic                      ram_we;
   logic [WA_W-1:0]           ram_addr;
   logic [MARK_WORD_BITS-1:0] ram_wdata;
   logic [MARK_WORD_BITS-1:0] ram_rdata;

   // combinational helpers
   logic [BS_W:0]             div_trial;
   logic                      div_ge;
   logic [SZ_W:0]             fit_sum;
   logic [SZ_W:0]             newtop_sum;
   logic [MARK_WORD_BITS-1:0] masked;
   logic                      found;
   logic [BIT_W-1:0]          hbit;
   logic [BLK_W-1:0]          found_blk;
   logic                      cfg_wr;
   logic                      out_free;

   // effective block size, clamped to the legal range
   always_comb begin
      if (bs_reg_ff < bra_pkg::BS_MIN) begin
         bs = bra_pkg::BS_MIN;
      end else if (bs_reg_ff > bra_pkg::BS_MAX) begin
         bs = bra_pkg::BS_MAX;
      end else begin
         bs = bs_reg_ff;
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr)
         bra_pkg::ADDR_BLOCK_SIZE: prdata = 32'(bs_reg_ff);
         bra_pkg::ADDR_STORE_ID:   prdata = store_id_ff;
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_reg_ff   <= bra_pkg::BS_RESET;
         store_id_ff <= '0;
      end else if (cfg_wr) begin
         unique case (paddr)
            bra_pkg::ADDR_BLOCK_SIZE: bs_reg_ff   <= pwdata[BS_W-1:0];
            bra_pkg::ADDR_STORE_ID:   store_id_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // divider step: shift in one dividend bit, subtract when it fits
   assign div_trial = {rem_ff, dvd_ff[SZ_W-1]};
   assign div_ge    = div_trial >= {1'b0, dsr_ff};

   // fit test and new top block
   assign fit_sum    = (SZ_W+1)'(size_ff) + (SZ_W+1)'(next_free_ff);
   assign newtop_sum = (SZ_W+1)'(top_ff) + (SZ_W+1)'(1) + (SZ_W+1)'(dvd_ff);

   // highest marked bit at or below the scan position
   always_comb begin
      hbit = '0;
      for (int i = 0; i < MARK_WORD_BITS; i++) begin
         masked[i] = ram_rdata[i] && (BIT_W'(i) <= pos_ff);
      end
      for (int i = 0; i < MARK_WORD_BITS; i++) begin
         if (masked[i]) begin
            hbit = BIT_W'(i);
         end
      end
      found = |masked;
   end
   assign found_blk = blk_ff - BLK_W'(pos_ff) + BLK_W'(hbit);

   // bitmap memory access
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = word_ff;
      ram_wdata = ram_rdata | (MARK_WORD_BITS'(1) << pos_ff);
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_addr  = clr_ff;
         ram_wdata = (clr_ff == '0) ? MARK_WORD_BITS'(1) : '0;
      end else if (state_ff == S_MARK_WR) begin
         ram_we = 1'b1;
      end
   end

   bra_ram #(
      .WIDTH (MARK_WORD_BITS),
      .DEPTH (WORDS)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (clr_ff == WA_W'(WORDS - 1)) state_in = S_IDLE;
         S_IDLE:      if (req.valid) state_in = S_CHECK;
         S_CHECK: begin
            if (kind_ff == bra_pkg::KIND_ALLOC) begin
               state_in = (fit_sum < (SZ_W+1)'(bs)) ? S_MUL : S_DIV;
            end else begin
               state_in = (qstore_ff != store_id_ff) ? S_FIN : S_DIV;
            end
         end
         S_DIV: begin
            if (cnt_ff == bra_pkg::DIV_CNT_W'(bra_pkg::DIV_STEPS - 1)) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            if (kind_ff == bra_pkg::KIND_ALLOC) begin
               state_in = (newtop_sum + (SZ_W+1)'(1) >= (SZ_W+1)'(MAX_BLOCKS)) ?
                          S_FIN : S_SPLIT;
            end else begin
               state_in = (dvd_ff >= SZ_W'(MAX_BLOCKS)) ? S_FIN : S_SPLIT;
            end
         end
         S_SPLIT: begin
            state_in = (kind_ff == bra_pkg::KIND_ALLOC) ? S_MARK_WAIT : S_SCAN_WAIT;
         end
         S_MARK_WAIT: state_in = S_MARK_WR;
         S_MARK_WR:   state_in = S_MUL;
         S_SCAN_WAIT: state_in = S_SCAN;
         S_SCAN:      state_in = found ? S_MUL : S_SCAN_WAIT;
         S_MUL:       state_in = S_FIN;
         S_FIN:       if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         next_free_ff <= bra_pkg::NEXT_FREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + WA_W'(1);
         end
         // result valid: load on finish, drop when taken
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_FIN && out_free) begin
            if (status_ff == bra_pkg::ST_OK && kind_ff == bra_pkg::KIND_ALLOC) begin
               if (fit_ff) begin
                  next_free_ff <= next_free_ff + BS_W'(size_ff);
               end else begin
                  top_ff       <= newtop_ff;
                  next_free_ff <= bytes_ff;
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            kind_ff   <= req.kind;
            size_ff   <= req.size;
            qstore_ff <= req.query_store;
            offset_ff <= req.offset;
            status_ff <= bra_pkg::ST_OK;
            fit_ff    <= 1'b0;
         end
         S_CHECK: begin
            dsr_ff  <= bs;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            dvd_ff  <= (kind_ff == bra_pkg::KIND_ALLOC) ? size_ff : offset_ff;
            mul_a_ff <= top_ff;
            if (kind_ff == bra_pkg::KIND_ALLOC) begin
               fit_ff <= fit_sum < (SZ_W+1)'(bs);
            end else if (qstore_ff != store_id_ff) begin
               status_ff <= bra_pkg::ST_WRONG_STORE;
            end
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + bra_pkg::DIV_CNT_W'(1);
            dvd_ff <= {dvd_ff[SZ_W-2:0], div_ge};
            rem_ff <= div_ge ? BS_W'(div_trial - {1'b0, dsr_ff}) : BS_W'(div_trial);
         end
         S_DIV_DONE: begin
            if (kind_ff == bra_pkg::KIND_ALLOC) begin
               newtop_ff <= BLK_W'(newtop_sum);
               bytes_ff  <= rem_ff;
               blk_ff    <= top_ff + BLK_W'(1);
               if (newtop_sum + (SZ_W+1)'(1) >= (SZ_W+1)'(MAX_BLOCKS)) begin
                  status_ff <= bra_pkg::ST_FULL;
               end
            end else begin
               blk_ff <= BLK_W'(dvd_ff);
               if (dvd_ff >= SZ_W'(MAX_BLOCKS)) begin
                  status_ff <= bra_pkg::ST_RANGE;
               end
            end
         end
         S_SPLIT: begin
            // word and bit of the block; the word width is a power of two
            word_ff  <= WA_W'(blk_ff >> BIT_W);
            pos_ff   <= BIT_W'(blk_ff);
            mul_a_ff <= blk_ff;
         end
         S_SCAN: begin
            if (found) begin
               blk_ff   <= found_blk;
               mul_a_ff <= found_blk;
            end else begin
               // step to the previous word, top bit
               blk_ff  <= blk_ff - BLK_W'(pos_ff) - BLK_W'(1);
               word_ff <= word_ff - WA_W'(1);
               pos_ff  <= BIT_W'(MARK_WORD_BITS - 1);
            end
         end
         S_MUL: begin
            prod_ff <= PROD_W'(mul_a_ff) * PROD_W'(bs);
         end
         S_FIN: begin
            if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_aoff_ff   <= '0;
               rsp_rsb_ff    <= '0;
               rsp_inrun_ff  <= '0;
               if (status_ff == bra_pkg::ST_OK) begin
                  if (kind_ff == bra_pkg::KIND_ALLOC) begin
                     rsp_aoff_ff <= fit_ff ?
                        bra_pkg::OFS_W'(prod_ff + PROD_W'(next_free_ff)) :
                        bra_pkg::OFS_W'(prod_ff);
                  end else begin
                     rsp_rsb_ff   <= bra_pkg::RSB_W'(blk_ff);
                     rsp_inrun_ff <= offset_ff - bra_pkg::OFS_W'(prod_ff);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // result channel
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.alloc_offset    = rsp_aoff_ff;
   assign rsp.run_start_block = rsp_rsb_ff;
   assign rsp.offset_in_run   = rsp_inrun_ff;
endmodule

### bench/tb_block_run_bump_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_run_bump_allocator_core: self-checking bench for the bump allocator
// Drives allocate and lookup requests with random idling and backpressure,
// predicts every result from a shadow copy of the allocator state, and checks
// each result field by field. Block size and store id change between phases.
// ----------------------------------------------------------------------------
module tb_block_run_bump_allocator_core;

   localparam int NUM_BLOCKS  = bra_pkg::MAX_BLOCKS_DEF;
   localparam int STALL_LIMIT = 6000;
   localparam int DRAIN_WAIT  = 300;

   typedef struct packed {
      logic [bra_pkg::KIND_W-1:0]  kind;
      logic [bra_pkg::SIZE_W-1:0]  size;
      logic [bra_pkg::STORE_W-1:0] query_store;
      logic [bra_pkg::OFS_W-1:0]   offset;
   } alloc_req_type;

   typedef struct packed {
      logic [bra_pkg::STATUS_W-1:0] status;
      logic [bra_pkg::OFS_W-1:0]    alloc_offset;
      logic [bra_pkg::RSB_W-1:0]    run_start_block;
      logic [bra_pkg::OFS_W-1:0]    offset_in_run;
   } alloc_rsp_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [bra_pkg::PADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bra_req_if req_if ();
   bra_rsp_if rsp_if ();

   block_run_bump_allocator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if.sink),
      .rsp     (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow allocator state and registers
   logic [bra_pkg::BS_W-1:0]    shadow_bs;
   logic [bra_pkg::STORE_W-1:0] shadow_store;
   longint unsigned      shadow_top;
   longint unsigned      shadow_next_free;
   bit [NUM_BLOCKS-1:0]  shadow_marks;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   int  error_count;
   int  rsp_count;
   int  quiet_cycles;
   bit  no_idle;
   bit  sender_hold;
   bit  req_taken;
   int  rsp_stall_left;
   bit  long_stall_done;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint unsigned eff_block_size(logic [bra_pkg::BS_W-1:0] raw);
      if (raw < bra_pkg::BS_MIN) return 64'(bra_pkg::BS_MIN);
      if (raw > bra_pkg::BS_MAX) return 64'(bra_pkg::BS_MAX);
      return 64'(raw);
   endfunction

   // compute the result of one request and advance the shadow state
   function automatic alloc_rsp_type predict_alloc(alloc_req_type r);
      alloc_rsp_type   res;
      longint unsigned bs;
      longint unsigned blocks;
      longint unsigned first_blk;
      longint unsigned new_top;
      longint unsigned blk;
      bs = eff_block_size(shadow_bs);
      res = '0;
      if (r.kind == bra_pkg::KIND_ALLOC) begin
         if (64'(r.size) + shadow_next_free < bs) begin
            res.alloc_offset = bra_pkg::OFS_W'(shadow_top * bs + shadow_next_free);
            shadow_next_free += 64'(r.size);
         end else begin
            blocks    = 64'(r.size) / bs;
            first_blk = shadow_top + 1;
            new_top   = first_blk + blocks;
            if (new_top + 1 >= NUM_BLOCKS) begin
               res.status = bra_pkg::ST_FULL;
            end else begin
               shadow_marks[first_blk] = 1'b1;
               res.alloc_offset = bra_pkg::OFS_W'(first_blk * bs);
               shadow_top       = new_top;
               shadow_next_free = 64'(r.size) % bs;
            end
         end
      end else if (r.query_store != shadow_store) begin
         res.status = bra_pkg::ST_WRONG_STORE;
      end else begin
         blk = 64'(r.offset) / bs;
         if (blk >= NUM_BLOCKS) begin
            res.status = bra_pkg::ST_RANGE;
         end else begin
            while (blk > 0 && !shadow_marks[blk]) blk--;
            res.run_start_block = bra_pkg::RSB_W'(blk);
            res.offset_in_run   = bra_pkg::OFS_W'(64'(r.offset) - blk * bs);
         end
      end
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && req_if.valid && !req_taken) begin
         // hold the offered request until it is taken
      end else if (!reset && !sender_hold && pending_reqs.size() > 0 &&
          (no_idle || $urandom_range(0, 99) >= 29)) begin
         req_if.valid       <= 1'b1;
         req_if.kind        <= pending_reqs[0].kind;
         req_if.size        <= pending_reqs[0].size;
         req_if.query_store <= pending_reqs[0].query_store;
         req_if.offset      <= pending_reqs[0].offset;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // result ready, with one long hold-off once enough results have come
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_if.ready   <= 1'b0;
      end else if (!long_stall_done && rsp_count >= 500) begin
         long_stall_done <= 1'b1;
         rsp_stall_left  <= 600;
         rsp_if.ready    <= 1'b0;
      end else begin
         rsp_if.ready <= no_idle || $urandom_range(0, 99) >= 29;
      end
   end

   // monitor: predict on request, check on result
   always @(posedge clock) begin
      alloc_req_type got_req;
      alloc_rsp_type want;
      alloc_rsp_type got;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            got_req = pending_reqs.pop_front();
            expected_rsps.push_back(predict_alloc(got_req));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            got = {rsp_if.status, rsp_if.alloc_offset, rsp_if.run_start_block,
                   rsp_if.offset_in_run};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                  error_count++;
               end
               if (got.alloc_offset !== want.alloc_offset) begin
                  $display("%0t: alloc_offset exp %0h got %0h", $time,
                           want.alloc_offset, got.alloc_offset);
                  error_count++;
               end
               if (got.run_start_block !== want.run_start_block) begin
                  $display("%0t: run_start_block exp %0d got %0d", $time,
                           want.run_start_block, got.run_start_block);
                  error_count++;
               end
               if (got.offset_in_run !== want.offset_in_run) begin
                  $display("%0t: offset_in_run exp %0h got %0h", $time,
                           want.offset_in_run, got.offset_in_run);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // register write over the config port, only while idle
   task automatic csr_write(logic [bra_pkg::PADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == bra_pkg::ADDR_BLOCK_SIZE) shadow_bs = data[bra_pkg::BS_W-1:0];
      else shadow_store = data;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_req(logic [bra_pkg::KIND_W-1:0] k, logic [bra_pkg::SIZE_W-1:0] s,
                           logic [bra_pkg::STORE_W-1:0] q, logic [bra_pkg::OFS_W-1:0] o);
      alloc_req_type r;
      r = '{kind: k, size: s, query_store: q, offset: o};
      pending_reqs.push_back(r);
   endtask

   // one random request, mostly well-formed with small sizes
   task automatic push_random();
      int unsigned bs;
      int unsigned pick;
      int unsigned span;
      logic [bra_pkg::SIZE_W-1:0]  s;
      logic [bra_pkg::STORE_W-1:0] q;
      logic [bra_pkg::OFS_W-1:0]   o;
      bs   = 32'(eff_block_size(shadow_bs));
      pick = $urandom_range(0, 99);
      s    = bra_pkg::SIZE_W'($urandom);
      q    = $urandom;
      o    = bra_pkg::OFS_W'($urandom);
      if (pick < 55) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) s = bra_pkg::SIZE_W'($urandom_range(0, bs / 4));
         else if (pick < 80) s = bra_pkg::SIZE_W'($urandom_range(0, 3 * bs));
         else if (pick < 96) s = bra_pkg::SIZE_W'($urandom_range(0, 6 * bs));
         push_req(bra_pkg::KIND_ALLOC, s, q, o);
      end else begin
         pick = $urandom_range(0, 99);
         span = 32'((shadow_top + 2) * bs);
         if (pick < 60) o = bra_pkg::OFS_W'($urandom_range(0, span - 1));
         else if (pick < 85) o = bra_pkg::OFS_W'($urandom_range(0, NUM_BLOCKS * bs - 1));
         if (pick < 92) q = shadow_store;
         push_req(bra_pkg::KIND_LOOKUP, s, q, o);
      end
   endtask

   task automatic run_phase(logic [bra_pkg::BS_W-1:0] bs, logic [bra_pkg::STORE_W-1:0] sid,
                            int count, bit pause_mid, bit busy);
      wait_drained();
      csr_write(bra_pkg::ADDR_BLOCK_SIZE, 32'(bs));
      csr_write(bra_pkg::ADDR_STORE_ID, sid);
      no_idle = busy;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) begin
            // sender waits for every outstanding result
            while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
            sender_hold = 1'b1;
            repeat (20) @(posedge clock);
            sender_hold = 1'b0;
         end
         push_random();
      end
      wait_drained();
      no_idle = 1'b0;
   endtask

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = '0;
      req_if.size = '0;
      req_if.query_store = '0;
      req_if.offset = '0;
      rsp_if.ready = 1'b0;
      error_count = 0;
      rsp_count = 0;
      quiet_cycles = 0;
      no_idle = 1'b0;
      sender_hold = 1'b0;
      req_taken = 1'b0;
      rsp_stall_left = 0;
      long_stall_done = 1'b0;
      shadow_bs = bra_pkg::BS_RESET;
      shadow_store = '0;
      shadow_top = 0;
      shadow_next_free = 64'(bra_pkg::NEXT_FREE_RESET);
      shadow_marks = '0;
      shadow_marks[0] = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset config, block size 4096, store 0
      push_req(bra_pkg::KIND_ALLOC, 27'd0, 32'hFFFF_FFFF, 27'h7FF_FFFF);
      push_req(bra_pkg::KIND_ALLOC, 27'd100, '0, '0);
      push_req(bra_pkg::KIND_ALLOC, 27'd3988, '0, '0);   // exactly fills: opens a run
      push_req(bra_pkg::KIND_ALLOC, 27'd5000, '0, '0);   // multi-block run
      push_req(bra_pkg::KIND_ALLOC, 27'h7FF_FFFF, '0, '0); // store full
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd0);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd4095);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd4096);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd12000); // inside second run block
      push_req(bra_pkg::KIND_LOOKUP, 27'h7FF_FFFF, 32'd0, 27'd400000); // above top block
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'hFFFF_FFFF, 27'd10);    // wrong store
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'h7FF_FFFF);      // out of range
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd8388607);       // last legal offset
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd8388608);       // first illegal offset
      push_req(bra_pkg::KIND_ALLOC, 27'd1, '0, '0);
      push_req(bra_pkg::KIND_ALLOC, 27'd40000, '0, '0);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd60000);
      wait_drained();

      // directed: store id all ones; the phases below cover the extremes of block size
      csr_write(bra_pkg::ADDR_STORE_ID, 32'hFFFF_FFFF);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'hFFFF_FFFF, 27'd20000);
      push_req(bra_pkg::KIND_LOOKUP, '0, 32'd0, 27'd20000);
      wait_drained();

      run_phase(17'd16, 32'hFFFF_FFFF, 250, 1'b1, 1'b0);
      run_phase(17'd65536, $urandom, 250, 1'b0, 1'b1);
      run_phase(17'd5, 32'd0, 200, 1'b0, 1'b0);            // below minimum
      run_phase(17'h1FFFF, $urandom, 150, 1'b0, 1'b0);     // above maximum
      run_phase(17'd100, $urandom, 200, 1'b0, 1'b0);
      run_phase(bra_pkg::BS_W'($urandom_range(16, 65536)), $urandom, 230, 1'b0, 1'b0);

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/bra_pkg.sv
hdl/bra_req_if.sv
hdl/bra_rsp_if.sv
hdl/bra_ram.sv
hdl/block_run_bump_allocator_core.sv
bench/tb_block_run_bump_allocator_core.sv
